// ===== rtl/seen_device_dedup_table_assert.svh =====
// ----------------------------------------------------------------------------
// seen device dedup table assertion macros
// shared property wrappers, clocked on clk and reset by arst_n
// ----------------------------------------------------------------------------
`ifndef SEEN_DEVICE_DEDUP_TABLE_ASSERT_SVH
`define SEEN_DEVICE_DEDUP_TABLE_ASSERT_SVH

// same-cycle implication
`define SDD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdd assertion failed");

// next-cycle implication
`define SDD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdd assertion failed");

`endif

// ===== rtl/sdd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdd_pkg
// types, widths and helpers shared by the dedup table cells and top level
// ----------------------------------------------------------------------------
package sdd_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int ADDR_W = 48;
	localparam int TIME_W = 32;
	localparam int RSSI_W = 8;
	localparam int TIER_W = 2;
	localparam int SLOT_W = 4;
	localparam int OCC_W = 5;

	localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd30000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE
	} state_t;

	// search token walking down the cell row
	typedef struct packed {
		logic              live;
		logic [ADDR_W-1:0] addr;
		logic              found;
		logic [IDX_W-1:0]  hit_idx;
		logic [TIME_W-1:0] hit_last;
		logic [TIME_W-1:0] min_last;
		logic [IDX_W-1:0]  min_idx;
	} tok_t;

	// table update broadcast to all cells
	typedef struct packed {
		logic              en;
		logic              fill;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] now;
		logic [RSSI_W-1:0] rssi;
		logic [TIER_W-1:0] tier;
		logic              cam;
	} wr_t;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W+SLOT_W-1:0] t;
		t = {{SLOT_W{1'b0}}, i};
		return t[SLOT_W-1:0];
	endfunction

	function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
		logic [CNT_W+OCC_W-1:0] t;
		t = {{OCC_W{1'b0}}, c};
		return t[OCC_W-1:0];
	endfunction

endpackage

// ===== rtl/seen_device_dedup_table.sv =====
// ----------------------------------------------------------------------------
// seen_device_dedup_table
// cooldown dedup of device detections over a row of table cells
// ----------------------------------------------------------------------------
// One detection is handled at a time. A search token enters the first cell at
// the accepting edge and moves one cell per cycle, collecting the first
// address match and the oldest last-seen entry. The token from the last cell
// is registered on entry to a decision state, in which the table is updated
// and the result registered. The input opens again the cycle after the
// decision, so a new detection is only taken once the previous one has
// been decided. The decision waits while a previous result is still
// pending on the output. No clearing pass is needed after reset.
module seen_device_dedup_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sdd_pkg::TIME_W-1:0] cooldown_ms,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sdd_pkg::ADDR_W-1:0] device_address,
	input  logic [sdd_pkg::TIME_W-1:0] now_time,
	input  logic signed [sdd_pkg::RSSI_W-1:0] signal_strength,
	input  logic [sdd_pkg::TIER_W-1:0] confidence_tier,
	input  logic                       camera_flag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       alert_passed,
	output logic [sdd_pkg::SLOT_W-1:0] slot_index,
	output logic                       new_entry,
	output logic                       evicted,
	output logic [sdd_pkg::OCC_W-1:0]  occupancy
);
	import sdd_pkg::*;
	`include "seen_device_dedup_table_assert.svh"

	state_t state_q;
	state_t state_nx;

	logic [TIME_W-1:0] cooldown_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nx;

	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;
	logic [RSSI_W-1:0] rssi_q;
	logic [TIER_W-1:0] tier_q;
	logic              cam_q;
	tok_t              fin_q;

	logic              out_valid_q;
	logic              alert_q;
	logic [SLOT_W-1:0] slot_q;
	logic              new_q;
	logic              evict_q;
	logic [OCC_W-1:0]  occ_q;

	tok_t chain [TABLE_DEPTH+1];
	wr_t  wr;

	logic              in_fire;
	logic              search_done;
	logic              decide_go;
	logic [TIME_W-1:0] elapsed;
	logic              suppress;
	logic              full;
	logic [IDX_W-1:0]  tgt_idx;

	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && in_ready;
	assign search_done = chain[TABLE_DEPTH].live;

	// token entering the first cell
	always_comb begin
		chain[0] = '0;
		chain[0].live = in_fire;
		chain[0].addr = device_address;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		sdd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.count    (count_q),
			.tok_in   (chain[g]),
			.tok_out  (chain[g+1]),
			.wr       (wr)
		);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_nx = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (search_done) state_nx = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (decide_go) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		decide_go = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SEARCH: ;
			ST_DECIDE: decide_go = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	// wrapping age against the cooldown window
	assign elapsed = now_q - fin_q.hit_last;
	assign suppress = fin_q.found && (elapsed < cooldown_q);
	assign full = count_q == CNT_W'(TABLE_DEPTH);

	always_comb begin
		if (fin_q.found) begin
			tgt_idx = fin_q.hit_idx;
		end else if (full) begin
			tgt_idx = fin_q.min_idx;
		end else begin
			tgt_idx = count_q[IDX_W-1:0];
		end
	end

	always_comb begin
		wr.en = decide_go && !suppress;
		wr.fill = !fin_q.found;
		wr.idx = tgt_idx;
		wr.addr = addr_q;
		wr.now = now_q;
		wr.rssi = rssi_q;
		wr.tier = tier_q;
		wr.cam = cam_q;
	end

	always_comb begin
		count_nx = count_q;
		if (!fin_q.found && !full) count_nx = count_q + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cooldown_q <= COOLDOWN_RESET;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) cooldown_q <= cooldown_ms;
			if (decide_go) count_q <= count_nx;
			if (decide_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q <= device_address;
			now_q <= now_time;
			rssi_q <= signal_strength;
			tier_q <= confidence_tier;
			cam_q <= camera_flag;
		end
		if (search_done) fin_q <= chain[TABLE_DEPTH];
		if (decide_go) begin
			alert_q <= !suppress;
			slot_q <= suppress ? '0 : to_slot(tgt_idx);
			new_q <= !fin_q.found;
			evict_q <= !fin_q.found && full;
			occ_q <= to_occ(count_nx);
		end
	end

	assign out_valid = out_valid_q;
	assign alert_passed = alert_q;
	assign slot_index = slot_q;
	assign new_entry = new_q;
	assign evicted = evict_q;
	assign occupancy = occ_q;

	`SDD_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`SDD_ASSERT_NEXT(a_accept_starts_search, in_fire, state_q == ST_SEARCH)
	`SDD_ASSERT_NOW(a_token_only_in_search, search_done, state_q == ST_SEARCH)
	`SDD_ASSERT_NOW(a_suppress_clean, out_valid && !alert_passed,
		!new_entry && !evicted && slot_index == '0)
	`SDD_ASSERT_NOW(a_evict_when_full, out_valid && evicted,
		new_entry && occupancy == to_occ(CNT_W'(TABLE_DEPTH)))

endmodule

// ===== rtl/sdd_cell.sv =====
// ----------------------------------------------------------------------------
// sdd_cell
// one table entry plus one stage of the search token pipeline
// ----------------------------------------------------------------------------
module sdd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [sdd_pkg::IDX_W-1:0] cell_idx,
	input  logic [sdd_pkg::CNT_W-1:0] count,
	input  sdd_pkg::tok_t             tok_in,
	output sdd_pkg::tok_t             tok_out,
	input  sdd_pkg::wr_t              wr
);
	import sdd_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] last_q;
	logic [RSSI_W-1:0] rssi_q;
	logic [TIER_W-1:0] tier_q;
	logic              cam_q;

	logic live_q;
	tok_t tok_q;
	tok_t tok_nx;
	logic valid;
	logic hit;
	logic take_min;

	assign valid = CNT_W'(cell_idx) < count;
	assign hit = tok_in.live && valid && !tok_in.found && (addr_q == tok_in.addr);
	// min only matters when the table is full, so every cell is valid then
	assign take_min = (cell_idx == '0) || (last_q < tok_in.min_last);

	always_comb begin
		tok_nx = tok_in;
		if (hit) begin
			tok_nx.found = 1'b1;
			tok_nx.hit_idx = cell_idx;
			tok_nx.hit_last = last_q;
		end
		if (take_min) begin
			tok_nx.min_last = last_q;
			tok_nx.min_idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= tok_in.live;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.live = live_q;
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx)) begin
			last_q <= wr.now;
			rssi_q <= wr.rssi;
			if (wr.fill) begin
				addr_q <= wr.addr;
				tier_q <= wr.tier;
				cam_q <= wr.cam;
			end
		end
	end

endmodule

// ===== tb/tb_seen_device_dedup_table.sv =====
// ----------------------------------------------------------------------------
// tb_seen_device_dedup_table
// self-checking bench for the cooldown dedup table of seen devices
// ----------------------------------------------------------------------------
// Detections are queued by phase, one cooldown setting per phase, and driven
// beat by beat with random gaps. Every accepted detection runs through a local
// copy of the table, which yields the expected alert, slot, insertion,
// eviction and occupancy. The monitor compares each result against the oldest
// expectation. The receiver idles at random and now and then holds off long
// enough to back the block up to its input.
module tb_seen_device_dedup_table;
	import sdd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_SIZE = 24;

	typedef struct packed {
		logic [ADDR_W-1:0]        addr;
		logic [TIME_W-1:0]        now;
		logic signed [RSSI_W-1:0] rssi;
		logic [TIER_W-1:0]        tier;
		logic                     cam;
	} detection_t;

	typedef struct packed {
		logic              alert;
		logic [SLOT_W-1:0] slot;
		logic              fresh;
		logic              evict;
		logic [OCC_W-1:0]  occ;
	} dedup_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [TIME_W-1:0]        cooldown_ms = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [ADDR_W-1:0]        device_address = '0;
	logic [TIME_W-1:0]        now_time = '0;
	logic signed [RSSI_W-1:0] signal_strength = '0;
	logic [TIER_W-1:0]        confidence_tier = '0;
	logic                     camera_flag = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     alert_passed;
	logic [SLOT_W-1:0]        slot_index;
	logic                     new_entry;
	logic                     evicted;
	logic [OCC_W-1:0]         occupancy;

	seen_device_dedup_table DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cooldown_ms     (cooldown_ms),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.device_address  (device_address),
		.now_time        (now_time),
		.signal_strength (signal_strength),
		.confidence_tier (confidence_tier),
		.camera_flag     (camera_flag),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.alert_passed    (alert_passed),
		.slot_index      (slot_index),
		.new_entry       (new_entry),
		.evicted         (evicted),
		.occupancy       (occupancy)
	);

	// local copy of the table
	logic [ADDR_W-1:0] seen_addr [TABLE_DEPTH];
	logic [TIME_W-1:0] seen_time [TABLE_DEPTH];
	logic [RSSI_W-1:0] seen_rssi [TABLE_DEPTH];
	logic [TIER_W-1:0] seen_tier [TABLE_DEPTH];
	logic              seen_cam  [TABLE_DEPTH];
	int                seen_count = 0;
	logic [TIME_W-1:0] cooldown_now = COOLDOWN_RESET;

	detection_t    detections_todo[$];
	dedup_result_t pending_verdicts[$];
	detection_t    cur_det;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	logic [TIME_W-1:0] now_cursor = '0;

	int  mismatches = 0;
	int  det_accepted = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  rx_next;
	int  hold_left = 0;
	int  hold_mark = 30;
	int  cycle_cnt = 0;
	bit  tx_burst = 1'b0;
	bit  rx_burst = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void store_entry(int slot, detection_t d);
		seen_addr[slot] = d.addr;
		seen_time[slot] = d.now;
		seen_rssi[slot] = d.rssi;
		seen_tier[slot] = d.tier;
		seen_cam[slot] = d.cam;
	endfunction

	// first-match lookup, cooldown test, append or replace-oldest
	function automatic dedup_result_t dedup_lookup(detection_t d);
		dedup_result_t r;
		int hit;
		int oldest;
		logic [TIME_W-1:0] age;
		r = '0;
		hit = -1;
		for (int i = 0; i < seen_count; i++) begin
			if (hit < 0 && seen_addr[i] == d.addr)
				hit = i;
		end
		if (hit >= 0) begin
			age = d.now - seen_time[hit];
			if (age >= cooldown_now) begin
				seen_time[hit] = d.now;
				seen_rssi[hit] = d.rssi;
				r.alert = 1'b1;
				r.slot = hit[SLOT_W-1:0];
			end
		end else if (seen_count < TABLE_DEPTH) begin
			store_entry(seen_count, d);
			r.slot = seen_count[SLOT_W-1:0];
			seen_count++;
			r.alert = 1'b1;
			r.fresh = 1'b1;
		end else begin
			oldest = 0;
			for (int i = 1; i < seen_count; i++) begin
				if (seen_time[i] < seen_time[oldest])
					oldest = i;
			end
			store_entry(oldest, d);
			r.slot = oldest[SLOT_W-1:0];
			r.alert = 1'b1;
			r.fresh = 1'b1;
			r.evict = 1'b1;
		end
		r.occ = seen_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic queue_det(input logic [ADDR_W-1:0] a, input logic [TIME_W-1:0] t,
			input logic [RSSI_W-1:0] s, input logic [TIER_W-1:0] tr, input logic c);
		detection_t d;
		d.addr = a;
		d.now = t;
		d.rssi = s;
		d.tier = tr;
		d.cam = c;
		detections_todo.push_back(d);
	endtask

	// mostly repeats from a small address pool, so matches, refreshes and
	// evictions all come up; time mostly creeps forward with the odd jump
	task automatic queue_random(input int n, input int step_max);
		int pick;
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = ADDR_W'({$urandom, $urandom});
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				now_cursor = $urandom;
			else if (pick > 1)
				now_cursor = now_cursor + $urandom_range(0, step_max);
			if ($urandom_range(0, 4) != 0)
				a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				a = ADDR_W'({$urandom, $urandom});
			queue_det(a, now_cursor, RSSI_W'($urandom_range(0, 255)),
				TIER_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_idle();
		while (detections_todo.size() != 0 || in_valid || pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cooldown(input logic [TIME_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cooldown_ms <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cooldown_now = v;
		cfg_valid <= 1'b0;
	endtask

	// sender: one beat at a time from the pending detections
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				pending_verdicts.push_back(dedup_lookup(cur_det));
				det_accepted <= det_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (detections_todo.size() > 0) begin
					cur_det = detections_todo.pop_front();
					device_address <= cur_det.addr;
					now_time <= cur_det.now;
					signal_strength <= cur_det.rssi;
					confidence_tier <= cur_det.tier;
					camera_flag <= cur_det.cam;
					in_valid <= 1'b1;
					tx_gap <= tx_burst ? 0 : $urandom_range(0, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, so a second detection piles up behind the first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_mark <= 30;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (det_accepted >= hold_mark) begin
			hold_left <= 300;
			hold_mark <= hold_mark + 200;
		end
	end

	// receiver: check each result beat, then idle a random number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			rx_next = rx_gap;
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("result beat with no detection outstanding");
					mismatches++;
				end else begin
					dedup_result_t exp_r;
					exp_r = pending_verdicts.pop_front();
					if (alert_passed !== exp_r.alert) begin
						$error("alert_passed: expected %0d, got %0d", exp_r.alert, alert_passed);
						mismatches++;
					end
					if (slot_index !== exp_r.slot) begin
						$error("slot_index: expected %0d, got %0d", exp_r.slot, slot_index);
						mismatches++;
					end
					if (new_entry !== exp_r.fresh) begin
						$error("new_entry: expected %0d, got %0d", exp_r.fresh, new_entry);
						mismatches++;
					end
					if (evicted !== exp_r.evict) begin
						$error("evicted: expected %0d, got %0d", exp_r.evict, evicted);
						mismatches++;
					end
					if (occupancy !== exp_r.occ) begin
						$error("occupancy: expected %0d, got %0d", exp_r.occ, occupancy);
						mismatches++;
					end
				end
				rx_next = rx_burst ? 0 : $urandom_range(0, 16);
			end else if (rx_next > 0) begin
				rx_next = rx_next - 1;
			end
			rx_gap <= rx_next;
			out_ready <= (rx_next == 0) && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset cooldown: suppression, expiry, fill-up, eviction ties, wrap
		queue_det(48'h0, 32'd1000, 8'h80, 2'd0, 1'b0);
		queue_det(48'h0, 32'd1500, 8'h01, 2'd1, 1'b1);
		queue_det(48'h0, 32'd31000, 8'h7f, 2'd3, 1'b1);
		queue_det(48'hFFFF_FFFF_FFFF, 32'd0, 8'h00, 2'd3, 1'b1);
		for (int i = 0; i < 14; i++)
			queue_det(48'h10 + ADDR_W'(i), 32'd5000, 8'h80 + 8'(i * 19), TIER_W'(i % 4),
				1'(i % 2));
		queue_det(48'hA5A5_5A5A_0F0F, 32'd6000, 8'hc4, 2'd2, 1'b0);
		queue_det(48'h5A5A_A5A5_F0F0, 32'd7000, 8'h3b, 2'd1, 1'b1);
		queue_det(48'hA5A5_5A5A_0F0F, 32'hFFFF_FFF0, 8'hff, 2'd0, 1'b0);
		queue_det(48'hA5A5_5A5A_0F0F, 32'h0000_0010, 8'hd0, 2'd0, 1'b1);
		queue_det(48'h0123_4567_89AB, 32'd8000, 8'h55, 2'd2, 1'b1);
		now_cursor = 32'd8000;

		// zero cooldown never suppresses
		write_cooldown('0);
		queue_random(90, 20000);

		// maximum cooldown: a repeat one tick earlier is a full wrap and passes
		write_cooldown('1);
		tx_burst = 1'b1;
		queue_det(48'hCAFE_0000_BEEF, now_cursor, 8'h22, 2'd1, 1'b0);
		queue_det(48'hCAFE_0000_BEEF, now_cursor - 1, 8'h23, 2'd2, 1'b1);
		queue_random(90, 20000);

		write_cooldown($urandom_range(200, 6000));
		tx_burst = 1'b0;
		rx_burst = 1'b1;
		queue_random(150, 2 * cooldown_now);

		write_cooldown(32'd1);
		rx_burst = 1'b0;
		queue_random(60, 3);

		write_cooldown(COOLDOWN_RESET);
		queue_random(60, 20000);

		wait_idle();
		repeat (2 * (TABLE_DEPTH + 2)) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d expected results never arrived", pending_verdicts.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
